[src/rc2_pkg.sv]
`timescale 1ns / 1ps
package rc2_pkg;

    localparam int KEY_DEPTH = 128;

    typedef enum logic [1:0] {
        ACT_KEY = 2'd0,
        ACT_ENC = 2'd1,
        ACT_DEC = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_KEY_READY = 2'd1,
        ST_KEY_ERR = 2'd2,
        ST_NO_KEY = 2'd3
    } status_t;

    // Command from the front end to the engine.
    typedef enum logic [1:0] {
        CMD_EXPAND = 2'd0,
        CMD_ENC = 2'd1,
        CMD_DEC = 2'd2,
        CMD_REPORT = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic [7:0] key_len;
        status_t status;
        logic [63:0] block;
    } cmd_t;

    typedef enum logic [3:0] {
        EN_IDLE,
        EN_FWD,
        EN_BACK_RD,
        EN_BACK_WR,
        EN_MASK_RD,
        EN_MASK_WR,
        EN_REV_RD,
        EN_REV_WR,
        EN_SK_RD,
        EN_SK_WR,
        EN_MIX,
        EN_MASH,
        EN_OUT
    } eng_state_t;

    function automatic logic [7:0] pi_lookup(input logic [7:0] idx);
        logic [7:0] t [256];
        t = '{
        8'hd9,8'h78,8'hf9,8'hc4,8'h19,8'hdd,8'hb5,8'hed,8'h28,8'he9,8'hfd,8'h79,8'h4a,8'ha0,8'hd8,8'h9d,
        8'hc6,8'h7e,8'h37,8'h83,8'h2b,8'h76,8'h53,8'h8e,8'h62,8'h4c,8'h64,8'h88,8'h44,8'h8b,8'hfb,8'ha2,
        8'h17,8'h9a,8'h59,8'hf5,8'h87,8'hb3,8'h4f,8'h13,8'h61,8'h45,8'h6d,8'h8d,8'h09,8'h81,8'h7d,8'h32,
        8'hbd,8'h8f,8'h40,8'heb,8'h86,8'hb7,8'h7b,8'h0b,8'hf0,8'h95,8'h21,8'h22,8'h5c,8'h6b,8'h4e,8'h82,
        8'h54,8'hd6,8'h65,8'h93,8'hce,8'h60,8'hb2,8'h1c,8'h73,8'h56,8'hc0,8'h14,8'ha7,8'h8c,8'hf1,8'hdc,
        8'h12,8'h75,8'hca,8'h1f,8'h3b,8'hbe,8'he4,8'hd1,8'h42,8'h3d,8'hd4,8'h30,8'ha3,8'h3c,8'hb6,8'h26,
        8'h6f,8'hbf,8'h0e,8'hda,8'h46,8'h69,8'h07,8'h57,8'h27,8'hf2,8'h1d,8'h9b,8'hbc,8'h94,8'h43,8'h03,
        8'hf8,8'h11,8'hc7,8'hf6,8'h90,8'hef,8'h3e,8'he7,8'h06,8'hc3,8'hd5,8'h2f,8'hc8,8'h66,8'h1e,8'hd7,
        8'h08,8'he8,8'hea,8'hde,8'h80,8'h52,8'hee,8'hf7,8'h84,8'haa,8'h72,8'hac,8'h35,8'h4d,8'h6a,8'h2a,
        8'h96,8'h1a,8'hd2,8'h71,8'h5a,8'h15,8'h49,8'h74,8'h4b,8'h9f,8'hd0,8'h5e,8'h04,8'h18,8'ha4,8'hec,
        8'hc2,8'he0,8'h41,8'h6e,8'h0f,8'h51,8'hcb,8'hcc,8'h24,8'h91,8'haf,8'h50,8'ha1,8'hf4,8'h70,8'h39,
        8'h99,8'h7c,8'h3a,8'h85,8'h23,8'hb8,8'hb4,8'h7a,8'hfc,8'h02,8'h36,8'h5b,8'h25,8'h55,8'h97,8'h31,
        8'h2d,8'h5d,8'hfa,8'h98,8'he3,8'h8a,8'h92,8'hae,8'h05,8'hdf,8'h29,8'h10,8'h67,8'h6c,8'hba,8'hc9,
        8'hd3,8'h00,8'he6,8'hcf,8'he1,8'h9e,8'ha8,8'h2c,8'h63,8'h16,8'h01,8'h3f,8'h58,8'he2,8'h89,8'ha9,
        8'h0d,8'h38,8'h34,8'h1b,8'hab,8'h33,8'hff,8'hb0,8'hbb,8'h48,8'h0c,8'h5f,8'hb9,8'hb1,8'hcd,8'h2e,
        8'hc5,8'hf3,8'hdb,8'h47,8'he5,8'ha5,8'h9c,8'h77,8'h0a,8'ha6,8'h20,8'h68,8'hfe,8'h7f,8'hc1,8'had
        };
        return t[idx];
    endfunction

endpackage

[src/rc2_front.sv]
`timescale 1ns / 1ps
module rc2_front
    import rc2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  key_byte,
    input  logic        key_last,
    input  logic [63:0] block_in,
    input  logic        eng_copy_done,
    output logic        kw_en,
    output logic [6:0]  kw_addr,
    output logic [7:0]  kw_data,
    output logic        q_push,
    output cmd_t        q_data,
    input  logic        q_full
);

    logic [7:0] key_count_reg, key_count_next;
    logic       key_overflow_reg, key_overflow_next;
    logic       expand_pending_reg, expand_pending_next;
    logic       accept;
    logic       has_room;

    // Hold key bytes until the engine has copied the previous key out of the store
    assign in_stall = q_full || (action == ACT_KEY && expand_pending_reg);
    assign accept = in_valid && !in_stall;
    assign has_room = key_count_reg < 8'(KEY_DEPTH);

    always_comb
    begin
        key_count_next = key_count_reg;
        key_overflow_next = key_overflow_reg;
        expand_pending_next = expand_pending_reg;
        kw_en = 1'b0;
        kw_addr = key_count_reg[6:0];
        kw_data = key_byte;
        q_push = 1'b0;
        q_data = '{kind: CMD_REPORT, key_len: key_count_reg, status: ST_NO_KEY,
                   block: block_in};
        if (eng_copy_done)
        begin
            expand_pending_next = 1'b0;
        end
        if (accept)
        begin
            case (action)
                ACT_KEY:
                begin
                    if (has_room)
                    begin
                        kw_en = 1'b1;
                        key_count_next = key_count_reg + 8'd1;
                    end
                    else
                    begin
                        key_overflow_next = 1'b1;
                    end
                    if (key_last)
                    begin
                        q_push = 1'b1;
                        q_data.kind = CMD_EXPAND;
                        q_data.key_len = key_count_next;
                        q_data.status = (key_overflow_next) ? ST_KEY_ERR : ST_KEY_READY;
                        key_count_next = 8'd0;
                        key_overflow_next = 1'b0;
                        expand_pending_next = 1'b1;
                    end
                end
                ACT_ENC, ACT_DEC:
                begin
                    q_push = 1'b1;
                    // the engine picks block or no-key when it pops the item
                    q_data.kind = (action == ACT_ENC) ? CMD_ENC : CMD_DEC;
                    q_data.status = ST_DONE;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= '0;
            key_overflow_reg <= 1'b0;
            expand_pending_reg <= 1'b0;
        end
        else
        begin
            key_count_reg <= key_count_next;
            key_overflow_reg <= key_overflow_next;
            expand_pending_reg <= expand_pending_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        kw_en |-> !key_count_reg[7])
        else $error("key write past store");
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == ACT_KEY && key_last) |=> key_count_reg == 8'd0)
        else $error("key count not cleared");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_data.kind == CMD_EXPAND) |-> q_data.key_len != 8'd0)
        else $error("empty key expand");

endmodule

[src/rc2_queue.sv]
`timescale 1ns / 1ps
module rc2_queue
    import rc2_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue count overrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && count_reg == 2'd1) |=> full)
        else $error("queue count lost");

endmodule

[src/rc2_engine.sv]
`timescale 1ns / 1ps
module rc2_engine
    import rc2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [10:0] effective_key_bits,
    input  logic        kw_en,
    input  logic [6:0]  kw_addr,
    input  logic [7:0]  kw_data,
    input  logic        q_not_empty,
    input  cmd_t        q_head,
    output logic        q_pop,
    output logic        copy_done,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] block_out,
    output logic [1:0]  status
);

    // Raw key bytes, written by the front end, and expansion buffer
    logic [7:0]  key_mem [KEY_DEPTH];
    logic [7:0]  buf_mem [KEY_DEPTH];
    logic [15:0] sk_mem [64];

    eng_state_t  state_reg, state_next;
    logic        key_valid_reg;
    logic        out_valid_reg;
    logic [63:0] out_block_reg;
    status_t     out_status_reg;

    logic [7:0]  idx_reg;
    logic [7:0]  n_reg;
    logic [7:0]  t8_reg;
    logic [7:0]  tm_reg;
    logic [7:0]  prev_reg;
    logic [7:0]  lo_reg;
    logic        dec_reg;
    status_t     kstat_reg;
    logic [3:0]  rnd_reg;
    logic [1:0]  sub_reg;
    logic        phase_reg;
    logic [15:0] r_reg [4];

    logic [10:0] t1;
    logic        out_free;
    logic [7:0]  key_rd_reg, buf_rd_reg;
    logic [6:0]  key_raddr, buf_raddr;
    logic        buf_we;
    logic [6:0]  buf_waddr;
    logic [7:0]  buf_wdata;
    logic [5:0]  sk_raddr;
    logic [15:0] sk_rd_reg;
    logic        sk_we;

    // The last raw key byte has been copied; the key store is free again
    assign copy_done = (state_reg == EN_FWD) && (idx_reg == n_reg);
    assign out_valid = out_valid_reg;
    assign block_out = out_block_reg;
    assign status = out_status_reg;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (effective_key_bits == 11'd0)
        begin
            t1 = 11'd1;
        end
        else if (effective_key_bits > 11'd1024)
        begin
            t1 = 11'd1024;
        end
        else
        begin
            t1 = effective_key_bits;
        end
    end

    always_ff @(posedge clk)
    begin
        if (kw_en)
        begin
            key_mem[kw_addr] <= kw_data;
        end
        key_rd_reg <= key_mem[key_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_waddr] <= buf_wdata;
        end
        buf_rd_reg <= buf_mem[buf_raddr];
    end

    // Subkey read is registered: a step presents its index, then computes next cycle
    always_ff @(posedge clk)
    begin
        if (sk_we)
        begin
            sk_mem[idx_reg[6:1]] <= {buf_rd_reg, lo_reg};
        end
        sk_rd_reg <= sk_mem[sk_raddr];
    end

    // Mixing datapath: each quarter-round has a subkey read phase, then a compute phase
    logic [1:0]  ia, ib, ic, id;
    logic [15:0] ra, rb, rc, rd, fsum, mixed, mashed;
    logic [15:0] v, rr;
    logic [5:0]  kidx;

    always_comb
    begin
        ia = sub_reg;
        ib = sub_reg + 2'd1;
        ic = sub_reg + 2'd2;
        id = sub_reg + 2'd3;
        ra = r_reg[ia];
        rb = r_reg[ib];
        rc = r_reg[ic];
        rd = r_reg[id];
        kidx = {rnd_reg, sub_reg};
        if (state_reg == EN_MASH)
        begin
            sk_raddr = rd[5:0];
        end
        else
        begin
            sk_raddr = kidx;
        end
        fsum = (rb & ~rd) + (rc & rd) + sk_rd_reg;
        if (!dec_reg)
        begin
            v = ra + fsum;
            unique case (sub_reg)
                2'd0: rr = {v[14:0], v[15]};
                2'd1: rr = {v[13:0], v[15:14]};
                2'd2: rr = {v[12:0], v[15:13]};
                default: rr = {v[10:0], v[15:11]};
            endcase
            mixed = rr;
            mashed = ra + sk_rd_reg;
        end
        else
        begin
            unique case (sub_reg)
                2'd0: rr = {ra[0], ra[15:1]};
                2'd1: rr = {ra[1:0], ra[15:2]};
                2'd2: rr = {ra[2:0], ra[15:3]};
                default: rr = {ra[4:0], ra[15:5]};
            endcase
            v = rr;
            mixed = rr - fsum;
            mashed = ra - sk_rd_reg;
        end
    end

    // Expansion memory addressing
    logic [7:0] cur_byte;
    always_comb
    begin
        key_raddr = idx_reg[6:0];
        buf_raddr = idx_reg[6:0];
        buf_we = 1'b0;
        buf_waddr = idx_reg[6:0];
        buf_wdata = key_rd_reg;
        sk_we = 1'b0;
        cur_byte = 8'd0;
        unique case (state_reg)
            EN_BACK_RD:
            begin
                buf_raddr = 7'(idx_reg - n_reg);
            end
            EN_MASK_RD:
            begin
                buf_raddr = 7'(8'd128 - t8_reg);
            end
            EN_REV_RD:
            begin
                buf_raddr = 7'(idx_reg + t8_reg);
            end
            default:
            begin
            end
        endcase
        unique case (state_reg)
            EN_FWD:
            begin
                buf_we = (idx_reg != 8'd0) && (idx_reg <= n_reg);
                buf_waddr = 7'(idx_reg - 8'd1);
            end
            EN_BACK_WR:
            begin
                buf_we = 1'b1;
                cur_byte = pi_lookup(prev_reg + buf_rd_reg);
                buf_wdata = cur_byte;
            end
            EN_MASK_WR:
            begin
                buf_we = 1'b1;
                buf_waddr = 7'(8'd128 - t8_reg);
                cur_byte = pi_lookup(buf_rd_reg & tm_reg);
                buf_wdata = cur_byte;
            end
            EN_REV_WR:
            begin
                buf_we = 1'b1;
                cur_byte = pi_lookup(prev_reg ^ buf_rd_reg);
                buf_wdata = cur_byte;
            end
            EN_SK_WR:
            begin
                sk_we = idx_reg[0];
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop = 1'b0;
        unique case (state_reg)
            EN_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop = 1'b1;
                    if (q_head.kind == CMD_EXPAND)
                    begin
                        state_next = EN_FWD;
                    end
                    else if (key_valid_reg)
                    begin
                        state_next = EN_MIX;
                    end
                    else
                    begin
                        state_next = EN_OUT;
                    end
                end
            end
            EN_FWD:
            begin
                if (idx_reg == n_reg)
                begin
                    state_next = (n_reg[7]) ? EN_MASK_RD : EN_BACK_RD;
                end
            end
            EN_BACK_RD: state_next = EN_BACK_WR;
            EN_BACK_WR: state_next = (idx_reg == 8'd127) ? EN_MASK_RD : EN_BACK_RD;
            EN_MASK_RD: state_next = EN_MASK_WR;
            EN_MASK_WR: state_next = (t8_reg == 8'd128) ? EN_SK_RD : EN_REV_RD;
            EN_REV_RD: state_next = EN_REV_WR;
            EN_REV_WR: state_next = (idx_reg == 8'd0) ? EN_SK_RD : EN_REV_RD;
            EN_SK_RD: state_next = EN_SK_WR;
            EN_SK_WR: state_next = (idx_reg == 8'd127) ? EN_OUT : EN_SK_RD;
            EN_MIX:
            begin
                if (phase_reg &&
                    ((!dec_reg && sub_reg == 2'd3) || (dec_reg && sub_reg == 2'd0)))
                begin
                    if (!dec_reg && (rnd_reg == 4'd4 || rnd_reg == 4'd10))
                    begin
                        state_next = EN_MASH;
                    end
                    else if (!dec_reg && rnd_reg == 4'd15)
                    begin
                        state_next = EN_OUT;
                    end
                    else if (dec_reg && rnd_reg == 4'd0)
                    begin
                        state_next = EN_OUT;
                    end
                    else if (dec_reg && (rnd_reg == 4'd5 || rnd_reg == 4'd11))
                    begin
                        state_next = EN_MASH;
                    end
                end
            end
            EN_MASH:
            begin
                if (phase_reg &&
                    ((!dec_reg && sub_reg == 2'd3) || (dec_reg && sub_reg == 2'd0)))
                begin
                    state_next = EN_MIX;
                end
            end
            EN_OUT:
            begin
                if (out_free)
                begin
                    state_next = EN_IDLE;
                end
            end
            default: state_next = EN_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            EN_IDLE:
            begin
                idx_reg <= '0;
                n_reg <= q_head.key_len;
                kstat_reg <= q_head.status;
                dec_reg <= q_head.kind == CMD_DEC;
                t8_reg <= 8'((t1 + 11'd7) >> 3);
                tm_reg <= 8'hFF >> (3'd0 - t1[2:0]);
                r_reg[0] <= q_head.block[15:0];
                r_reg[1] <= q_head.block[31:16];
                r_reg[2] <= q_head.block[47:32];
                r_reg[3] <= q_head.block[63:48];
                rnd_reg <= (q_head.kind == CMD_DEC) ? 4'd15 : 4'd0;
                sub_reg <= (q_head.kind == CMD_DEC) ? 2'd3 : 2'd0;
                phase_reg <= 1'b0;
            end
            EN_FWD:
            begin
                if (idx_reg == n_reg)
                begin
                    prev_reg <= key_rd_reg;
                    if (n_reg[7])
                    begin
                        idx_reg <= 8'd0;
                    end
                end
                else
                begin
                    idx_reg <= idx_reg + 8'd1;
                end
            end
            EN_BACK_WR:
            begin
                prev_reg <= cur_byte;
                idx_reg <= idx_reg + 8'd1;
            end
            EN_MASK_WR:
            begin
                prev_reg <= cur_byte;
                idx_reg <= 8'd127 - t8_reg;
                if (t8_reg == 8'd128)
                begin
                    idx_reg <= 8'd0;
                end
            end
            EN_REV_WR:
            begin
                prev_reg <= cur_byte;
                // stop at byte 0 so the subkey pass starts there
                if (idx_reg != 8'd0)
                begin
                    idx_reg <= idx_reg - 8'd1;
                end
            end
            EN_REV_RD, EN_BACK_RD, EN_MASK_RD:
            begin
            end
            EN_SK_RD:
            begin
            end
            EN_SK_WR:
            begin
                lo_reg <= buf_rd_reg;
                idx_reg <= idx_reg + 8'd1;
            end
            EN_MIX:
            begin
                if (!phase_reg)
                begin
                    phase_reg <= 1'b1;
                end
                else
                begin
                    phase_reg <= 1'b0;
                    r_reg[ia] <= mixed;
                    if (!dec_reg)
                    begin
                        sub_reg <= sub_reg + 2'd1;
                        if (sub_reg == 2'd3)
                        begin
                            rnd_reg <= rnd_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        sub_reg <= sub_reg - 2'd1;
                        if (sub_reg == 2'd0)
                        begin
                            rnd_reg <= rnd_reg - 4'd1;
                        end
                    end
                end
            end
            EN_MASH:
            begin
                if (!phase_reg)
                begin
                    phase_reg <= 1'b1;
                end
                else
                begin
                    phase_reg <= 1'b0;
                    r_reg[ia] <= mashed;
                    sub_reg <= dec_reg ? sub_reg - 2'd1 : sub_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EN_IDLE;
            key_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_block_reg <= '0;
            out_status_reg <= ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == EN_SK_WR && idx_reg == 8'd127)
            begin
                key_valid_reg <= 1'b1;
            end
            if (state_reg == EN_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (kstat_reg == ST_DONE && key_valid_reg)
                begin
                    out_block_reg <= {r_reg[3], r_reg[2], r_reg[1], r_reg[0]};
                    out_status_reg <= ST_DONE;
                end
                else
                begin
                    out_block_reg <= '0;
                    out_status_reg <= (kstat_reg == ST_DONE) ? ST_NO_KEY : kstat_reg;
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(block_out))
        else $error("result dropped under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == EN_IDLE)
        else $error("pop while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_DONE) |-> block_out == 64'd0)
        else $error("non-block result carries data");

endmodule

[src/rc2_block_cipher.sv]
`timescale 1ns / 1ps
// RC2 block cipher with on-chip key expansion.
// Input channel (in_valid / in_stall): action, key_byte, key_last, block_in.
//   Action 0 stores a key byte; with key_last set the key is expanded and
//   one result reports status 1 (ready) or 2 (more than 128 bytes offered).
//   Actions 1 and 2 encrypt or decrypt block_in; status 3 if no key yet.
//   Action 3 is dropped with no result.
// Output channel (out_valid / out_stall): block_out, status.
// A two-entry command queue separates the accept side from the round engine.
// A keyed block holds the engine for a pop, 64 mixing plus 8 mash steps, each a
// subkey read then compute (mixing adds and rotates, or rotates and subtracts to
// decrypt), and a result that waits while the output is stalled.
// Key expansion holds it through the copy of the n key bytes, the backward fill,
// the mask step and the reverse fill (t8 effective key bytes), then the subkey pass.
// Key bytes of the next key stall until the engine has copied the last key.
// effective_key_bits is written through cfg_we/cfg_data; the user must write it
// only while idle, the block does not enforce it; 0 acts as 1. Reset clears the
// key (blocks then report no key) and sets 1024 key bits. A stalled result holds;
// the engine waits and the queue then fills, raising in_stall.
module rc2_block_cipher
    import rc2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  key_byte,
    input  logic        key_last,
    input  logic [63:0] block_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] block_out,
    output logic [1:0]  status,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data
);

    logic [10:0] ekb_reg;
    logic        kw_en, q_push, q_full, q_pop, q_not_empty, copy_done;
    logic [6:0]  kw_addr;
    logic [7:0]  kw_data;
    cmd_t        q_in, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ekb_reg <= 11'd1024;
        end
        else if (cfg_we)
        begin
            ekb_reg <= cfg_data;
        end
    end

    rc2_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .key_byte(key_byte), .key_last(key_last),
        .block_in(block_in), .eng_copy_done(copy_done), .kw_en(kw_en),
        .kw_addr(kw_addr), .kw_data(kw_data), .q_push(q_push), .q_data(q_in),
        .q_full(q_full)
    );

    rc2_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_not_empty), .head(q_head)
    );

    rc2_engine u_engine (
        .clk(clk), .rst_n(rst_n), .effective_key_bits(ekb_reg), .kw_en(kw_en),
        .kw_addr(kw_addr), .kw_data(kw_data), .q_not_empty(q_not_empty),
        .q_head(q_head), .q_pop(q_pop), .copy_done(copy_done),
        .out_valid(out_valid), .out_stall(out_stall), .block_out(block_out),
        .status(status)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result withdrawn under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> ekb_reg == $past(cfg_data))
        else $error("config write lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(status))
        else $error("status moved under stall");

endmodule
